FILE: rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and codes for the strict priority ready queues
// Command codes, result status codes and fixed field widths.
// ----------------------------------------------------------------------------
package spq_pkg;

	// fixed field widths of the item and result ports
	localparam int unsigned CMD_W   = 1;
	localparam int unsigned PID_W   = 8;
	localparam int unsigned PRIO_W  = 3;
	localparam int unsigned LEVEL_W = 2;

	// one queue per priority level, level 0 is real time
	localparam int unsigned NUM_LEVELS = 4;

	typedef logic [CMD_W-1:0] cmd_t;
	localparam cmd_t CMD_ADD  = 1'b0;
	localparam cmd_t CMD_TAKE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_FULL    = 2'd2,
		ST_IGNORED = 2'd3
	} status_t;

	typedef logic [LEVEL_W-1:0] level_t;

endpackage

FILE: rtl/core/strict_priority_ready_queues.sv
// ----------------------------------------------------------------------------
// strict_priority_ready_queues: four FIFO ready queues with strict priority
// Result: an accepted item gives its result in the output register in the
//   cycle after the transfer. Throughput: one item per cycle while the
//   result is free or taken; the store has a single registered read port.
// Reset: arst_n clears all head/tail pointers, fill counts and the output
//   valid at once. The queue store is not cleared; no clearing pass is run.
// ----------------------------------------------------------------------------
module strict_priority_ready_queues #(
	parameter int unsigned QUEUE_DEPTH = 16,
	parameter int unsigned ID_WIDTH    = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,

	// item channel
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [spq_pkg::CMD_W-1:0]    command,
	input  logic [spq_pkg::PID_W-1:0]    process_id,
	input  logic [spq_pkg::PRIO_W-1:0]   priority_req,

	// result channel
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   status,
	output logic [spq_pkg::PID_W-1:0]    taken_id,
	output logic [spq_pkg::LEVEL_W-1:0]  taken_level,
	output logic                         all_empty
);

	// pointer and occupancy widths follow the queue depth
	localparam int unsigned PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
	// only the low ID_WIDTH bits of an identifier are kept, and never more
	// than the port carries
	localparam int unsigned KEEP_W = (ID_WIDTH < spq_pkg::PID_W) ? ID_WIDTH : spq_pkg::PID_W;

	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	// advance a ring pointer, wrap from the last entry back to zero
	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_LAST) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// queue state
	// ------------------------------------------------------------------
	logic [PTR_W-1:0]  head_q [spq_pkg::NUM_LEVELS];
	logic [PTR_W-1:0]  tail_q [spq_pkg::NUM_LEVELS];
	logic [CNT_W-1:0]  cnt_q  [spq_pkg::NUM_LEVELS];
	logic [CNT_W-1:0]  cnt_d  [spq_pkg::NUM_LEVELS];

	// queue store: one row per level, one write or one read per cycle
	logic [KEEP_W-1:0] store_mem [spq_pkg::NUM_LEVELS][QUEUE_DEPTH];

	// output register
	logic              out_valid_q;
	spq_pkg::status_t  status_q;
	spq_pkg::level_t   level_q;
	logic              all_empty_q;
	logic              take_ok_q;
	logic [KEEP_W-1:0] rd_data_q;

	// ------------------------------------------------------------------
	// decode of the item at the input
	// ------------------------------------------------------------------
	logic                   in_fire;
	logic                   is_add;
	logic                   prio_ok;
	spq_pkg::level_t        add_lvl;
	logic                   add_full;
	logic [spq_pkg::NUM_LEVELS-1:0] non_empty;
	logic                   take_hit;
	spq_pkg::level_t        take_lvl;
	logic                   do_push;
	logic                   do_pop;
	logic                   empty_after;
	spq_pkg::status_t       status_d;

	// take a new item whenever the result register is free or draining
	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	assign is_add   = (command == spq_pkg::CMD_ADD);
	assign prio_ok  = (priority_req < spq_pkg::PRIO_W'(spq_pkg::NUM_LEVELS));
	assign add_lvl  = priority_req[spq_pkg::LEVEL_W-1:0];
	assign add_full = (cnt_q[add_lvl] == CNT_FULL);

	// fixed four-way priority encoder: lowest-numbered non-empty level wins
	always_comb begin
		take_lvl = '0;
		for (int l = 0; l < spq_pkg::NUM_LEVELS; l++) begin
			non_empty[l] = (cnt_q[l] != '0);
		end
		for (int l = spq_pkg::NUM_LEVELS - 1; l >= 0; l--) begin
			if (non_empty[l]) begin
				take_lvl = spq_pkg::LEVEL_W'(l);
			end
		end
	end

	assign take_hit = |non_empty;
	assign do_push  = in_fire && is_add && prio_ok && !add_full;
	assign do_pop   = in_fire && !is_add && take_hit;

	// next occupancy; push and pop never happen together
	always_comb begin
		for (int l = 0; l < spq_pkg::NUM_LEVELS; l++) begin
			cnt_d[l] = cnt_q[l];
		end
		if (do_push) begin
			cnt_d[add_lvl] = cnt_q[add_lvl] + CNT_W'(1);
		end
		if (do_pop) begin
			cnt_d[take_lvl] = cnt_q[take_lvl] - CNT_W'(1);
		end
		empty_after = 1'b1;
		for (int l = 0; l < spq_pkg::NUM_LEVELS; l++) begin
			if (cnt_d[l] != '0) begin
				empty_after = 1'b0;
			end
		end
	end

	// result status of this item
	always_comb begin
		if (is_add) begin
			if (!prio_ok) begin
				status_d = spq_pkg::ST_IGNORED;
			end else if (add_full) begin
				status_d = spq_pkg::ST_FULL;
			end else begin
				status_d = spq_pkg::ST_OK;
			end
		end else if (take_hit) begin
			status_d = spq_pkg::ST_OK;
		end else begin
			status_d = spq_pkg::ST_EMPTY;
		end
	end

	// ------------------------------------------------------------------
	// pointers and fill counts
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < spq_pkg::NUM_LEVELS; l++) begin
				head_q[l] <= '0;
				tail_q[l] <= '0;
				cnt_q[l]  <= '0;
			end
		end else begin
			for (int l = 0; l < spq_pkg::NUM_LEVELS; l++) begin
				cnt_q[l] <= cnt_d[l];
			end
			if (do_push) begin
				tail_q[add_lvl] <= bump(tail_q[add_lvl]);
			end
			if (do_pop) begin
				head_q[take_lvl] <= bump(head_q[take_lvl]);
			end
		end
	end

	// ------------------------------------------------------------------
	// queue store: write the tail on push, read the head on pop; the read
	// data register doubles as the identifier field of the result
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (do_push) begin
			store_mem[add_lvl][tail_q[add_lvl]] <= process_id[KEEP_W-1:0];
		end
		if (do_pop) begin
			rd_data_q <= store_mem[take_lvl][head_q[take_lvl]];
		end
	end

	// ------------------------------------------------------------------
	// result register: load on every transfer in, drop valid once taken
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			status_q    <= status_d;
			level_q     <= do_pop ? take_lvl : '0;
			all_empty_q <= empty_after;
			take_ok_q   <= do_pop;
		end
	end

	// identifier and level read as zero unless the item was a good take
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign taken_level = level_q;
	assign taken_id    = take_ok_q ? spq_pkg::PID_W'(rd_data_q) : '0;
	assign all_empty   = all_empty_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------

	// no queue ever holds more than its depth
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q[0] <= CNT_FULL) && (cnt_q[1] <= CNT_FULL) &&
		(cnt_q[2] <= CNT_FULL) && (cnt_q[3] <= CNT_FULL))
		else $error("fill count above queue depth");

	// a take that finds any queue occupied must succeed
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && !is_add && take_hit) |=> (status_q == spq_pkg::ST_OK) && take_ok_q)
		else $error("take with occupied queue did not succeed");

	// an empty-take result can only come when every queue is empty
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q == spq_pkg::ST_EMPTY)) |-> all_empty_q)
		else $error("empty status while queues still occupied");

	// a nonzero level is reported only for a good take
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (level_q != '0)) |-> (take_ok_q && (status_q == spq_pkg::ST_OK)))
		else $error("taken level reported without a take");

endmodule

FILE: sim/strict_priority_ready_queues_tb.sv
// ----------------------------------------------------------------------------
// strict_priority_ready_queues_tb: self-checking bench for the ready queues
// Drives add and take items through the valid/ready item channel with random
// gaps and back-pressures the result channel with random stalls. A small
// scoreboard keeps its own copy of the four priority queues, predicts every
// result at the input transfer and compares it field by field at the output
// transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module strict_priority_ready_queues_tb;

	localparam int unsigned QUEUE_DEPTH = 16;
	localparam int unsigned ID_WIDTH    = 8;
	localparam int unsigned RANDOM_ITEMS = 1300;

	typedef struct {
		spq_pkg::status_t          status;
		logic [spq_pkg::PID_W-1:0] taken_id;
		spq_pkg::level_t           taken_level;
		logic                      all_empty;
	} queue_result_t;

	// Mirror of the four ready queues plus the results still in flight.
	class ready_queue_scoreboard;
		logic [spq_pkg::PID_W-1:0] slots [spq_pkg::NUM_LEVELS][QUEUE_DEPTH];
		int               head [spq_pkg::NUM_LEVELS];
		int               tail [spq_pkg::NUM_LEVELS];
		int               fill [spq_pkg::NUM_LEVELS];
		queue_result_t    awaited [$];
		int               errors;

		function new();
			for (int l = 0; l < spq_pkg::NUM_LEVELS; l++) begin
				head[l] = 0;
				tail[l] = 0;
				fill[l] = 0;
			end
			errors = 0;
		endfunction

		// Apply one accepted item to the mirror and queue its result.
		function void note_item(spq_pkg::cmd_t cmd, logic [spq_pkg::PID_W-1:0] pid,
			logic [spq_pkg::PRIO_W-1:0] prio);
			queue_result_t r;
			int            lvl;
			bit            found;
			r.status      = spq_pkg::ST_OK;
			r.taken_id    = '0;
			r.taken_level = '0;
			found         = 1'b0;
			if (cmd == spq_pkg::CMD_ADD) begin
				if (prio >= spq_pkg::NUM_LEVELS) begin
					r.status = spq_pkg::ST_IGNORED;
				end else begin
					lvl = int'(prio);
					if (fill[lvl] >= QUEUE_DEPTH) begin
						r.status = spq_pkg::ST_FULL;
					end else begin
						slots[lvl][tail[lvl]] = pid;
						tail[lvl] = (tail[lvl] + 1) % QUEUE_DEPTH;
						fill[lvl]++;
					end
				end
			end else begin
				r.status = spq_pkg::ST_EMPTY;
				for (lvl = 0; lvl < spq_pkg::NUM_LEVELS; lvl++) begin
					if (!found && fill[lvl] != 0) begin
						found         = 1'b1;
						r.status      = spq_pkg::ST_OK;
						r.taken_id    = slots[lvl][head[lvl]];
						r.taken_level = spq_pkg::level_t'(lvl);
						head[lvl] = (head[lvl] + 1) % QUEUE_DEPTH;
						fill[lvl]--;
					end
				end
			end
			r.all_empty = 1'b1;
			for (lvl = 0; lvl < spq_pkg::NUM_LEVELS; lvl++)
				if (fill[lvl] != 0)
					r.all_empty = 1'b0;
			awaited.push_back(r);
		endfunction

		task report_mismatch(string msg);
			$display("%0t ns mismatch: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(logic [1:0] st, logic [spq_pkg::PID_W-1:0] id,
			spq_pkg::level_t lvl, logic emp);
			queue_result_t want;
			if (awaited.size() == 0) begin
				report_mismatch("result transfer with no item outstanding");
			end else begin
				want = awaited.pop_front();
				if (st !== want.status)
					report_mismatch($sformatf("status %0d, want %0d", st, want.status));
				if (id !== want.taken_id)
					report_mismatch($sformatf("taken_id %0h, want %0h", id, want.taken_id));
				if (lvl !== want.taken_level)
					report_mismatch($sformatf("taken_level %0d, want %0d", lvl,
						want.taken_level));
				if (emp !== want.all_empty)
					report_mismatch($sformatf("all_empty %0b, want %0b", emp,
						want.all_empty));
			end
		endtask

		task close_out();
			if (awaited.size() != 0)
				report_mismatch($sformatf("%0d results never arrived", awaited.size()));
		endtask
	endclass

	logic                       clk          = 1'b0;
	logic                       arst_n       = 1'b0;
	logic                       in_valid     = 1'b0;
	logic                       in_ready;
	spq_pkg::cmd_t              command      = spq_pkg::CMD_ADD;
	logic [spq_pkg::PID_W-1:0]  process_id   = '0;
	logic [spq_pkg::PRIO_W-1:0] priority_req = '0;
	logic                       out_valid;
	logic                       out_ready    = 1'b0;
	logic [1:0]                 status;
	logic [spq_pkg::PID_W-1:0]  taken_id;
	spq_pkg::level_t            taken_level;
	logic                       all_empty;

	// no idling on either side while set
	bit calm = 1'b0;

	ready_queue_scoreboard sb = new();

	strict_priority_ready_queues #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.ID_WIDTH   (ID_WIDTH)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.process_id  (process_id),
		.priority_req(priority_req),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.taken_id    (taken_id),
		.taken_level (taken_level),
		.all_empty   (all_empty)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watch both channels at every edge. Note the input transfer first so a
	// prediction is always in place before its result can show up.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_item(command, process_id, priority_req);
			if (out_valid && out_ready)
				sb.check_result(status, taken_id, taken_level, all_empty);
		end
	end

	// Present one item after a random gap and hold it until the transfer.
	task send_item(spq_pkg::cmd_t cmd, logic [spq_pkg::PID_W-1:0] pid,
		logic [spq_pkg::PRIO_W-1:0] prio);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		command      <= cmd;
		process_id   <= pid;
		priority_req <= prio;
		do @(posedge clk); while (!in_ready);
	endtask

	// Result side: hold out_ready low for a random stall before each transfer.
	// With no stall, keep out_ready high so back-to-back transfers occur.
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		int counted;
		int burst_len;
		int add_pct;
		int favored;
		int pick;
		int spins;
		spq_pkg::cmd_t              cmd;
		logic [spq_pkg::PRIO_W-1:0] prio;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: take from empty queues, ignored priorities, both id
		// extremes on level 0, strict level order on the way out.
		send_item(spq_pkg::CMD_TAKE, 8'hFF, 3'd7);
		send_item(spq_pkg::CMD_ADD,  8'hFF, 3'd7);
		send_item(spq_pkg::CMD_ADD,  8'h00, 3'd4);
		send_item(spq_pkg::CMD_ADD,  8'hA5, 3'd3);
		send_item(spq_pkg::CMD_ADD,  8'h5A, 3'd2);
		send_item(spq_pkg::CMD_ADD,  8'hFF, 3'd1);
		send_item(spq_pkg::CMD_ADD,  8'h00, 3'd0);
		send_item(spq_pkg::CMD_ADD,  8'hFF, 3'd0);
		send_item(spq_pkg::CMD_ADD,  8'h00, 3'd3);
		send_item(spq_pkg::CMD_TAKE, 8'h00, 3'd0);
		send_item(spq_pkg::CMD_TAKE, 8'hFF, 3'd5);
		send_item(spq_pkg::CMD_TAKE, 8'h00, 3'd0);
		send_item(spq_pkg::CMD_TAKE, 8'h00, 3'd0);
		send_item(spq_pkg::CMD_TAKE, 8'h00, 3'd0);
		send_item(spq_pkg::CMD_TAKE, 8'h00, 3'd0);
		send_item(spq_pkg::CMD_TAKE, 8'hFF, 3'd7);

		// Random bursts: fill-heavy bursts drive a favored level into the full
		// refusal and wrap its pointers, drain-heavy bursts empty everything.
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			burst_len = $urandom_range(20, 80);
			pick      = $urandom_range(0, 2);
			add_pct   = (pick == 0) ? 85 : (pick == 1) ? 50 : 15;
			favored   = $urandom_range(0, spq_pkg::NUM_LEVELS - 1);
			calm      = ($urandom_range(0, 3) == 0);
			repeat (burst_len) begin
				cmd  = ($urandom_range(0, 99) < add_pct) ? spq_pkg::CMD_ADD
					: spq_pkg::CMD_TAKE;
				pick = $urandom_range(0, 9);
				if (pick == 0)
					prio = spq_pkg::PRIO_W'($urandom_range(spq_pkg::NUM_LEVELS, 7));
				else if (pick < 6)
					prio = spq_pkg::PRIO_W'(favored);
				else
					prio = spq_pkg::PRIO_W'($urandom_range(0, spq_pkg::NUM_LEVELS - 1));
				send_item(cmd, spq_pkg::PID_W'($urandom), prio);
				// ignored adds do nothing, so leave them out of the count
				if (!(cmd == spq_pkg::CMD_ADD && prio >= spq_pkg::NUM_LEVELS))
					counted++;
			end
		end
		in_valid <= 1'b0;
		calm     = 1'b0;

		// Drain: wait for every outstanding result, then close out the scoreboard.
		spins = 0;
		while (sb.awaited.size() != 0 && spins < 5000) begin
			@(posedge clk);
			spins++;
		end
		repeat (8) @(posedge clk);
		sb.close_out();

		if (sb.errors == 0)
			$display("strict_priority_ready_queues_tb: PASS");
		else
			$display("strict_priority_ready_queues_tb: FAIL");
		$finish;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#2ms;
		$display("strict_priority_ready_queues_tb: FAIL");
		$finish;
	end

endmodule
